// File: rtl/tctb_pkg.sv
// ----------------------------------------------------------------------------
// tctb_pkg
// Shared types and codes for the character-cell text terminal buffer.
// ----------------------------------------------------------------------------
package tctb_pkg;

    // Event modes
    localparam logic [1:0] MODE_KEY  = 2'd0;
    localparam logic [1:0] MODE_CHAR = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    // Cursor keys
    localparam logic [7:0] KEY_HOME   = 8'd0;
    localparam logic [7:0] KEY_END    = 8'd1;
    localparam logic [7:0] KEY_PGUP   = 8'd2;
    localparam logic [7:0] KEY_PGDN   = 8'd3;
    localparam logic [7:0] KEY_LEFT   = 8'd4;
    localparam logic [7:0] KEY_RIGHT  = 8'd5;
    localparam logic [7:0] KEY_UP     = 8'd6;
    localparam logic [7:0] KEY_DOWN   = 8'd7;
    localparam logic [7:0] KEY_DELETE = 8'd8;

    // Control characters
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LINEFEED  = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_ESCAPE    = 8'h1B;
    localparam logic [7:0] SPACE_CHAR   = 8'h20;

    // Configuration register indexes
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    localparam logic [7:0] RESET_COLUMNS = 8'd80;
    localparam logic [6:0] RESET_ROWS    = 7'd25;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] code;
        logic [7:0] repeat_count;
        logic [6:0] read_column;
        logic [5:0] read_row;
    } req_t;

    typedef struct packed {
        logic [6:0] caret_column;
        logic [5:0] caret_row;
        logic [7:0] cell_value;
    } rsp_t;

    typedef struct packed {
        logic [7:0] columns_in_use;
        logic [6:0] rows_in_use;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_TAB,
        ST_DEL_START,
        ST_DEL_RUN,
        ST_DEL_TAIL,
        ST_READ_WAIT
    } state_t;

endpackage

// File: rtl/tctb_mem.sv
// ----------------------------------------------------------------------------
// tctb_mem
// Cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tctb_mem #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13,
    parameter int DW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/tctb_ctrl.sv
// ----------------------------------------------------------------------------
// tctb_ctrl
// Event sequencer: caret, repeat loop, row delete, clear sweep, cell read.
// ----------------------------------------------------------------------------
module tctb_ctrl #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64,
    parameter int TAB_STOP    = 8,
    parameter int DEPTH       = 8192,
    parameter int AW          = 13
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  tctb_pkg::req_t  req,
    output logic            busy,
    output logic            done,
    output tctb_pkg::rsp_t  rsp,
    input  tctb_pkg::cfg_t  cfg,
    output logic            mem_we,
    output logic [AW-1:0]   mem_waddr,
    output logic [7:0]      mem_wdata,
    output logic            mem_re,
    output logic [AW-1:0]   mem_raddr,
    input  logic [7:0]      mem_rdata
);

    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CNW = $clog2(MAX_COLUMNS + 1);
    localparam int RNW = $clog2(MAX_ROWS + 1);

    function automatic logic [MAX_COLUMNS-1:0] tab_mask_f();
        logic [MAX_COLUMNS-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_COLUMNS; i++)
        begin
            m[i] = ((i % TAB_STOP) == 0);
        end
        return m;
    endfunction

    // bit c set when column c is a tab stop
    localparam logic [MAX_COLUMNS-1:0] TAB_MASK = tab_mask_f();

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] col,
                                                 input logic [RW-1:0] row);
        return AW'(AW'(row) * AW'(MAX_COLUMNS) + AW'(col));
    endfunction

    tctb_pkg::state_t state_reg, state_next;
    tctb_pkg::req_t   req_reg, req_next;
    tctb_pkg::rsp_t   rsp_reg, rsp_next;
    logic [CW-1:0]    caret_col_reg, caret_col_next;
    logic [RW-1:0]    caret_row_reg, caret_row_next;
    logic [7:0]       rep_cnt_reg, rep_cnt_next;
    logic [CW-1:0]    dx_reg, dx_next;
    logic [7:0]       cell_reg, cell_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic             clr_ret_reg, clr_ret_next;
    logic             done_reg, done_next;

    logic [CNW-1:0]   cols_eff;
    logic [RNW-1:0]   rows_eff;
    logic [CW-1:0]    col_last;
    logic [RW-1:0]    row_last;
    logic [CNW-1:0]   col_inc;
    logic             col_at_end;
    logic [RNW-1:0]   row_inc;
    logic             row_wrap;
    logic [RW-1:0]    row_step;
    logic [CW-1:0]    col_adv;
    logic [RW-1:0]    row_adv;
    logic [CNW-1:0]   dx_plus2;
    logic             read_in_range;

    // size registers saturated into 1..MAX
    always_comb
    begin
        if (9'(cfg.columns_in_use) > 9'(MAX_COLUMNS))
            cols_eff = CNW'(MAX_COLUMNS);
        else if (cfg.columns_in_use == 8'd0)
            cols_eff = CNW'(1);
        else
            cols_eff = CNW'(cfg.columns_in_use);

        if (8'(cfg.rows_in_use) > 8'(MAX_ROWS))
            rows_eff = RNW'(MAX_ROWS);
        else if (cfg.rows_in_use == 7'd0)
            rows_eff = RNW'(1);
        else
            rows_eff = RNW'(cfg.rows_in_use);
    end

    assign col_last   = CW'(cols_eff - CNW'(1));
    assign row_last   = RW'(rows_eff - RNW'(1));
    assign col_inc    = CNW'(caret_col_reg) + CNW'(1);
    assign col_at_end = (col_inc >= cols_eff);
    assign row_inc    = RNW'(caret_row_reg) + RNW'(1);
    assign row_wrap   = (row_inc >= rows_eff);
    assign row_step   = row_wrap ? '0 : RW'(row_inc);
    assign col_adv    = col_at_end ? '0 : CW'(col_inc);
    assign row_adv    = col_at_end ? row_step : caret_row_reg;
    assign dx_plus2   = CNW'(dx_reg) + CNW'(2);
    assign read_in_range = (9'(req_reg.read_column) < 9'(cols_eff)) &&
                           (8'(req_reg.read_row) < 8'(rows_eff));

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        caret_col_next = caret_col_reg;
        caret_row_next = caret_row_reg;
        rep_cnt_next   = rep_cnt_reg;
        dx_next        = dx_reg;
        cell_next      = cell_reg;
        clr_addr_next  = clr_addr_reg;
        clr_ret_next   = clr_ret_reg;
        done_next      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = cell_addr(caret_col_reg, caret_row_reg);
        mem_wdata      = tctb_pkg::SPACE_CHAR;
        mem_re         = 1'b0;
        mem_raddr      = cell_addr(CW'(col_inc), caret_row_reg);

        unique case (state_reg)
            tctb_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    clr_ret_next = 1'b0;
                    state_next   = clr_ret_reg ? tctb_pkg::ST_EXEC : tctb_pkg::ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end

            tctb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    req_next  = req;
                    cell_next = 8'd0;
                    // caret pulled back inside a shrunken screen
                    if (CNW'(caret_col_reg) >= cols_eff)
                        caret_col_next = col_last;
                    if (RNW'(caret_row_reg) >= rows_eff)
                        caret_row_next = row_last;
                    rep_cnt_next = (req.mode == tctb_pkg::MODE_CHAR) ? req.repeat_count
                                                                     : 8'd1;
                    state_next   = tctb_pkg::ST_EXEC;
                end
            end

            tctb_pkg::ST_EXEC:
            begin
                if (rep_cnt_reg == 8'd0)
                begin
                    done_next = 1'b1;
                    rsp_next  = '{caret_column: 7'(caret_col_reg),
                                  caret_row:    6'(caret_row_reg),
                                  cell_value:   cell_reg};
                    state_next = tctb_pkg::ST_IDLE;
                end
                else
                begin
                    rep_cnt_next = rep_cnt_reg - 8'd1;
                    unique case (req_reg.mode)
                        tctb_pkg::MODE_KEY:
                        begin
                            unique case (req_reg.code)
                                tctb_pkg::KEY_HOME:   caret_col_next = '0;
                                tctb_pkg::KEY_END:    caret_col_next = col_last;
                                tctb_pkg::KEY_PGUP:   caret_row_next = '0;
                                tctb_pkg::KEY_PGDN:   caret_row_next = row_last;
                                tctb_pkg::KEY_LEFT:
                                begin
                                    if (caret_col_reg != '0)
                                        caret_col_next = caret_col_reg - CW'(1);
                                end
                                tctb_pkg::KEY_RIGHT:
                                begin
                                    if (!col_at_end)
                                        caret_col_next = CW'(col_inc);
                                end
                                tctb_pkg::KEY_UP:
                                begin
                                    if (caret_row_reg != '0)
                                        caret_row_next = caret_row_reg - RW'(1);
                                end
                                tctb_pkg::KEY_DOWN:
                                begin
                                    if (!row_wrap)
                                        caret_row_next = RW'(row_inc);
                                end
                                tctb_pkg::KEY_DELETE: state_next = tctb_pkg::ST_DEL_START;
                                default: ;
                            endcase
                        end

                        tctb_pkg::MODE_CHAR:
                        begin
                            unique case (req_reg.code)
                                tctb_pkg::CH_BACKSPACE:
                                begin
                                    if (caret_col_reg != '0)
                                    begin
                                        caret_col_next = caret_col_reg - CW'(1);
                                        state_next     = tctb_pkg::ST_DEL_START;
                                    end
                                end
                                tctb_pkg::CH_TAB:      state_next = tctb_pkg::ST_TAB;
                                tctb_pkg::CH_LINEFEED: caret_row_next = row_step;
                                tctb_pkg::CH_RETURN:
                                begin
                                    caret_col_next = '0;
                                    caret_row_next = row_step;
                                end
                                tctb_pkg::CH_ESCAPE:
                                begin
                                    // repeats of escape change nothing more
                                    caret_col_next = '0;
                                    caret_row_next = '0;
                                    rep_cnt_next   = 8'd0;
                                    clr_addr_next  = '0;
                                    clr_ret_next   = 1'b1;
                                    state_next     = tctb_pkg::ST_CLEAR;
                                end
                                default:
                                begin
                                    mem_we         = 1'b1;
                                    mem_wdata      = req_reg.code;
                                    caret_col_next = col_adv;
                                    caret_row_next = row_adv;
                                end
                            endcase
                        end

                        tctb_pkg::MODE_READ:
                        begin
                            if (read_in_range)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = cell_addr(CW'(req_reg.read_column),
                                                       RW'(req_reg.read_row));
                                state_next = tctb_pkg::ST_READ_WAIT;
                            end
                            else
                            begin
                                cell_next = tctb_pkg::SPACE_CHAR;
                            end
                        end

                        default: ;
                    endcase
                end
            end

            tctb_pkg::ST_TAB:
            begin
                mem_we         = 1'b1;
                caret_col_next = col_adv;
                caret_row_next = row_adv;
                if (TAB_MASK[col_adv])
                    state_next = tctb_pkg::ST_EXEC;
            end

            tctb_pkg::ST_DEL_START:
            begin
                dx_next = caret_col_reg;
                if (!col_at_end)
                begin
                    mem_re     = 1'b1;
                    state_next = tctb_pkg::ST_DEL_RUN;
                end
                else
                begin
                    state_next = tctb_pkg::ST_DEL_TAIL;
                end
            end

            tctb_pkg::ST_DEL_RUN:
            begin
                // cell dx takes cell dx+1, read in the cycle before
                mem_we    = 1'b1;
                mem_waddr = cell_addr(dx_reg, caret_row_reg);
                mem_wdata = mem_rdata;
                if (dx_plus2 < cols_eff)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cell_addr(CW'(dx_plus2), caret_row_reg);
                    dx_next   = dx_reg + CW'(1);
                end
                else
                begin
                    state_next = tctb_pkg::ST_DEL_TAIL;
                end
            end

            tctb_pkg::ST_DEL_TAIL:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cell_addr(col_last, caret_row_reg);
                state_next = tctb_pkg::ST_EXEC;
            end

            tctb_pkg::ST_READ_WAIT:
            begin
                cell_next  = mem_rdata;
                state_next = tctb_pkg::ST_EXEC;
            end

            default: state_next = tctb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tctb_pkg::ST_CLEAR;
            caret_col_reg <= '0;
            caret_row_reg <= '0;
            rep_cnt_reg   <= '0;
            clr_addr_reg  <= '0;
            clr_ret_reg   <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            caret_col_reg <= caret_col_next;
            caret_row_reg <= caret_row_next;
            rep_cnt_reg   <= rep_cnt_next;
            clr_addr_reg  <= clr_addr_next;
            clr_ret_reg   <= clr_ret_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        rsp_reg  <= rsp_next;
        dx_reg   <= dx_next;
        cell_reg <= cell_next;
    end

    assign busy = (state_reg != tctb_pkg::ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// File: rtl/text_cell_terminal_buffer_top.sv
// ----------------------------------------------------------------------------
// text_cell_terminal_buffer_top
// Character-cell screen store with a caret, driven by key and character events.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: req is taken at a clock edge with start high and busy low.
//   Result channel: done pulses for one cycle with rsp (caret and read cell);
//   the receiver must take it then, there is no back-pressure.
//   Config: wr_en / wr_index / wr_data write the size registers (index 0 =
//   columns, 1 = rows); write only while idle, then send an escape request.
// Work per request: a tab writes up to TAB_STOP cells per repeat; a delete
//   or backspace walks the row one cell a cycle; escape sweeps the whole
//   store, MAX_COLUMNS * MAX_ROWS cells (8192 at defaults).
// The single write port of the cell memory writes one cell per cycle. A new
// request is taken in the cycle that done shows.
// Reset: caret to 0,0, sizes to 80 x 25, then a clearing pass fills the whole
//   store with spaces; busy stays high until it ends. Config writes are taken
//   during the pass.
// ----------------------------------------------------------------------------
module text_cell_terminal_buffer_top #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64,
    parameter int TAB_STOP    = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  tctb_pkg::req_t req,
    output logic           done,
    output tctb_pkg::rsp_t rsp,
    input  logic           wr_en,
    input  logic           wr_index,
    input  logic [7:0]     wr_data
);

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    tctb_pkg::cfg_t cfg_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    // size registers, plain write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.columns_in_use <= tctb_pkg::RESET_COLUMNS;
            cfg_reg.rows_in_use    <= tctb_pkg::RESET_ROWS;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                tctb_pkg::REG_COLUMNS: cfg_reg.columns_in_use <= wr_data;
                tctb_pkg::REG_ROWS:    cfg_reg.rows_in_use    <= wr_data[6:0];
                default: ;
            endcase
        end
    end

    // sequencer: owns caret, repeat count and all store accesses
    tctb_ctrl #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .TAB_STOP    (TAB_STOP),
        .DEPTH       (DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp),
        .cfg       (cfg_reg),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // cell store, row-major: cell (c, r) at r * MAX_COLUMNS + c
    tctb_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (8)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // result only ever issued as the sequencer returns to idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done while busy");

    // an accepted request always occupies the sequencer
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accept did not start work");

    // no result pulses back to back
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held for two cycles");

    // row delete reads ahead two cells from the cell it writes
    assert property (@(posedge clk) disable iff (!rst_n)
                     (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write hit the same cell");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the character-cell terminal buffer: a scripted
// opening, then random key, character and read requests under several screen
// sizes, each result checked against a typed answer or a cycle-free model.
// ----------------------------------------------------------------------------
module tb_top;

    // Geometry of the instance under test
    localparam int GRID_COLUMNS = 128;
    localparam int GRID_ROWS    = 64;
    localparam int TAB_WIDTH    = 8;
    localparam int GRID_CELLS   = GRID_COLUMNS * GRID_ROWS;

    // Codes the package does not name
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [7:0] KEY_TOP     = 8'hFF;   // highest (unknown) key code
    localparam logic [7:0] CHAR_TOP    = 8'hFF;   // highest printable byte

    // Run shape
    localparam int RANDOM_ITEMS    = 1100;
    localparam int PHASE_COUNT     = 10;
    localparam int ITEMS_PER_PHASE = RANDOM_ITEMS / PHASE_COUNT;
    localparam int SETTLE_CYCLES   = 4;
    localparam int CYCLE_LIMIT     = 4_000_000;
    localparam int PRINT_LIMIT     = 25;

    // Size settings per phase: max, small, zero (acts as 1), all ones (acts as
    // max), one above max, odd sizes. Some phases resize without an escape,
    // so the caret gets clamped and old cells stay in place.
    localparam int PHASE_COLS [PHASE_COUNT] = '{128, 8, 0, 255, 129, 13, 1, 128, 30, 80};
    localparam int PHASE_ROWS [PHASE_COUNT] = '{ 64, 2, 0, 255,  65,  5, 64,   1,  7, 25};
    localparam bit PHASE_ESC  [PHASE_COUNT] = '{  1, 0, 0,   0,   1,  1,  0,   0,  1,  0};

    logic   clk = 1'b0;
    logic   rst_n;
    logic   start;
    logic   busy;
    tctb_pkg::req_t req;
    logic   done;
    tctb_pkg::rsp_t rsp;
    logic   wr_en;
    logic   wr_index;
    logic   [7:0] wr_data;

    // Shadow of the screen store, caret and size registers
    logic   [7:0] shadow_cells [GRID_CELLS];
    int unsigned  caret_x;
    int unsigned  caret_y;
    logic   [7:0] cols_setting;
    logic   [6:0] rows_setting;

    // Caret/cell reports owed by the block, oldest first
    tctb_pkg::rsp_t caret_reports_due [$];
    tctb_pkg::rsp_t oldest_report;

    // Scripted opening: request plus, where obvious, the report typed in
    typedef struct {
        tctb_pkg::req_t stim;
        bit             typed;
        tctb_pkg::rsp_t want;
    } script_row_t;
    script_row_t script_rows [$];

    int     sender_idle_pct;
    int     mismatch_count;
    int     requests_sent;
    int     results_checked;
    int     escapes_sent;
    int     cycle_count;

    text_cell_terminal_buffer_top #(
        .MAX_COLUMNS (GRID_COLUMNS),
        .MAX_ROWS    (GRID_ROWS),
        .TAB_STOP    (TAB_WIDTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Screen model
    // ------------------------------------------------------------------------

    // Size registers as the block uses them: 0 acts as 1, above max as max
    function automatic int unsigned used_cols();
        if (cols_setting == 0) return 1;
        if (cols_setting > GRID_COLUMNS) return GRID_COLUMNS;
        return cols_setting;
    endfunction

    function automatic int unsigned used_rows();
        if (rows_setting == 0) return 1;
        if (rows_setting > GRID_ROWS) return GRID_ROWS;
        return rows_setting;
    endfunction

    function automatic void blank_screen();
        foreach (shadow_cells[i])
            shadow_cells[i] = tctb_pkg::SPACE_CHAR;
    endfunction

    function automatic void advance_row(int unsigned rows);
        caret_y++;
        if (caret_y >= rows)
            caret_y = 0;
    endfunction

    // Delete at the caret: rest of the row moves left, last used cell blanks
    function automatic void shift_row_left(int unsigned cols);
        int unsigned x;
        int unsigned base;
        base = caret_y * GRID_COLUMNS;
        for (x = caret_x; x + 1 < cols; x++)
            shadow_cells[base + x] = shadow_cells[base + x + 1];
        shadow_cells[base + cols - 1] = tctb_pkg::SPACE_CHAR;
    endfunction

    function automatic void put_glyph(logic [7:0] ch, int unsigned cols, int unsigned rows);
        shadow_cells[caret_y * GRID_COLUMNS + caret_x] = ch;
        caret_x++;
        if (caret_x >= cols)
        begin
            caret_x = 0;
            advance_row(rows);
        end
    endfunction

    function automatic void press_key(logic [7:0] key, int unsigned cols, int unsigned rows);
        case (key)
            tctb_pkg::KEY_HOME:   caret_x = 0;
            tctb_pkg::KEY_END:    caret_x = cols - 1;
            tctb_pkg::KEY_PGUP:   caret_y = 0;
            tctb_pkg::KEY_PGDN:   caret_y = rows - 1;
            tctb_pkg::KEY_LEFT:   if (caret_x > 0) caret_x--;
            tctb_pkg::KEY_RIGHT:  if (caret_x + 1 < cols) caret_x++;
            tctb_pkg::KEY_UP:     if (caret_y > 0) caret_y--;
            tctb_pkg::KEY_DOWN:   if (caret_y + 1 < rows) caret_y++;
            tctb_pkg::KEY_DELETE: shift_row_left(cols);
            default:    ;   // unknown key: no effect
        endcase
    endfunction

    function automatic void type_char(logic [7:0] ch, int unsigned cols, int unsigned rows);
        case (ch)
            tctb_pkg::CH_BACKSPACE:
            begin
                // nothing happens at column 0
                if (caret_x > 0)
                begin
                    caret_x--;
                    shift_row_left(cols);
                end
            end
            tctb_pkg::CH_TAB:
            begin
                do
                    put_glyph(tctb_pkg::SPACE_CHAR, cols, rows);
                while ((caret_x % TAB_WIDTH) != 0);
            end
            tctb_pkg::CH_LINEFEED: advance_row(rows);
            tctb_pkg::CH_RETURN:
            begin
                caret_x = 0;
                advance_row(rows);
            end
            tctb_pkg::CH_ESCAPE:
            begin
                // whole grid, not only the part in use
                blank_screen();
                caret_x = 0;
                caret_y = 0;
            end
            default: put_glyph(ch, cols, rows);
        endcase
    endfunction

    // Applies one request to the shadow state, returns the report it owes
    function automatic tctb_pkg::rsp_t apply_terminal_event(tctb_pkg::req_t r);
        int unsigned    cols;
        int unsigned    rows;
        int unsigned    n;
        logic [7:0]     cell_byte;
        tctb_pkg::rsp_t report;
        cols      = used_cols();
        rows      = used_rows();
        cell_byte = 8'h00;
        // a resize without escape leaves the caret outside: clamp first
        if (caret_x >= cols) caret_x = cols - 1;
        if (caret_y >= rows) caret_y = rows - 1;
        case (r.mode)
            tctb_pkg::MODE_KEY:  press_key(r.code, cols, rows);
            tctb_pkg::MODE_CHAR:
            begin
                for (n = 0; n < r.repeat_count; n++)
                    type_char(r.code, cols, rows);
            end
            tctb_pkg::MODE_READ:
            begin
                // outside the part in use reads as a space
                if (r.read_column < cols && r.read_row < rows)
                    cell_byte = shadow_cells[r.read_row * GRID_COLUMNS + r.read_column];
                else
                    cell_byte = tctb_pkg::SPACE_CHAR;
            end
            default:   ;   // unused mode: report only
        endcase
        report.caret_column = caret_x[6:0];
        report.caret_row    = caret_y[5:0];
        report.cell_value   = cell_byte;
        return report;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    function automatic tctb_pkg::req_t make_random_request();
        tctb_pkg::req_t r;
        int   pick;
        int   kind;
        r.mode         = tctb_pkg::MODE_KEY;
        r.code         = 8'($urandom);
        r.repeat_count = 8'($urandom);
        r.read_column  = 7'($urandom);
        r.read_row     = 6'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            r.mode = tctb_pkg::MODE_KEY;
            if ($urandom_range(0, 19) == 0)
                r.code = 8'($urandom_range(tctb_pkg::KEY_DELETE + 1, KEY_TOP));
            else
                r.code = 8'($urandom_range(tctb_pkg::KEY_HOME, tctb_pkg::KEY_DELETE));
        end
        else if (pick < 75)
        begin
            r.mode = tctb_pkg::MODE_CHAR;
            kind   = $urandom_range(0, 99);
            if (kind < 50)
            begin
                // any byte; escape is slow, so steer it elsewhere here
                if (r.code == tctb_pkg::CH_ESCAPE)
                    r.code = r.code ^ 8'h40;
                if ($urandom_range(0, 9) != 0)
                    r.repeat_count = 8'($urandom_range(1, 4));
            end
            else if (kind < 62)
            begin
                r.code = tctb_pkg::CH_BACKSPACE;
                r.repeat_count = ($urandom_range(0, 19) == 0) ?
                                 8'($urandom_range(4, 40)) : 8'($urandom_range(1, 3));
            end
            else if (kind < 72)
            begin
                r.code         = tctb_pkg::CH_TAB;
                r.repeat_count = 8'($urandom_range(1, 3));
            end
            else if (kind < 92)
            begin
                r.code = (kind < 82) ? tctb_pkg::CH_LINEFEED : tctb_pkg::CH_RETURN;
                if ($urandom_range(0, 4) != 0)
                    r.repeat_count = 8'($urandom_range(1, 3));
            end
            else if (kind < 95)
            begin
                r.code         = tctb_pkg::CH_ESCAPE;
                r.repeat_count = 8'($urandom_range(0, 2));
            end
            else
            begin
                r.code         = 8'($urandom_range(tctb_pkg::SPACE_CHAR, 8'h7E));
                r.repeat_count = 8'($urandom_range(1, 8));
            end
        end
        else if (pick < 95)
        begin
            r.mode = tctb_pkg::MODE_READ;
            // mostly inside the used area, where written cells live
            if ($urandom_range(0, 9) < 7)
            begin
                r.read_column = 7'($urandom_range(0, used_cols() - 1));
                r.read_row    = 6'($urandom_range(0, used_rows() - 1));
            end
        end
        else
            r.mode = MODE_UNUSED;
        return r;
    endfunction

    task automatic add_row(input logic [1:0] mode, input logic [7:0] code,
                           input logic [7:0] reps, input logic [6:0] rcol,
                           input logic [5:0] rrow, input bit typed,
                           input logic [6:0] col, input logic [5:0] row,
                           input logic [7:0] cell_byte);
        script_row_t s;
        s.stim.mode         = mode;
        s.stim.code         = code;
        s.stim.repeat_count = reps;
        s.stim.read_column  = rcol;
        s.stim.read_row     = rrow;
        s.typed             = typed;
        s.want.caret_column = col;
        s.want.caret_row    = row;
        s.want.cell_value   = cell_byte;
        script_rows.push_back(s);
    endtask

    // Drives one request, holds it until taken, then books its report
    task automatic issue_request(input tctb_pkg::req_t r, input bit typed,
                                 input tctb_pkg::rsp_t typed_rsp);
        tctb_pkg::rsp_t predicted;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = apply_terminal_event(r);
        caret_reports_due.push_back(typed ? typed_rsp : predicted);
        requests_sent++;
        if (r.mode == tctb_pkg::MODE_CHAR && r.code == tctb_pkg::CH_ESCAPE &&
            r.repeat_count != 0)
            escapes_sent++;
    endtask

    // Sender holds off until every owed report is in, then lets the block settle
    task automatic drain_reports();
        start <= 1'b0;
        while (caret_reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_size(input logic [7:0] cols, input logic [7:0] rows);
        wr_en    <= 1'b1;
        wr_index <= tctb_pkg::REG_COLUMNS;
        wr_data  <= cols;
        @(posedge clk);
        cols_setting = cols;
        wr_index <= tctb_pkg::REG_ROWS;
        wr_data  <= rows;
        @(posedge clk);
        rows_setting = rows[6:0];
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_LIMIT)
            $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Result check: done is sampled at the edge that ends its cycle
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (caret_reports_due.size() == 0)
                report_mismatch("report with nothing owed", int'(rsp), 0);
            else
            begin
                oldest_report = caret_reports_due.pop_front();
                results_checked++;
                if (rsp.caret_column !== oldest_report.caret_column)
                    report_mismatch("caret_column", int'(rsp.caret_column),
                                    int'(oldest_report.caret_column));
                if (rsp.caret_row !== oldest_report.caret_row)
                    report_mismatch("caret_row", int'(rsp.caret_row),
                                    int'(oldest_report.caret_row));
                if (rsp.cell_value !== oldest_report.cell_value)
                    report_mismatch("cell_value", int'(rsp.cell_value),
                                    int'(oldest_report.cell_value));
            end
        end
    end

    // Watchdog: a hung handshake or a lost report ends here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d reports still owed",
                     cycle_count, caret_reports_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        tctb_pkg::req_t escape_req;
        int   p;
        int   k;
        int   random_done;

        rst_n           = 1'b0;
        start           = 1'b0;
        req             = '0;
        wr_en           = 1'b0;
        wr_index        = tctb_pkg::REG_COLUMNS;
        wr_data         = '0;
        cycle_count     = 0;
        mismatch_count  = 0;
        requests_sent   = 0;
        results_checked = 0;
        escapes_sent    = 0;
        random_done     = 0;
        sender_idle_pct = 38;

        blank_screen();
        caret_x      = 0;
        caret_y      = 0;
        cols_setting = tctb_pkg::RESET_COLUMNS;
        rows_setting = tctb_pkg::RESET_ROWS;

        escape_req              = '0;
        escape_req.mode         = tctb_pkg::MODE_CHAR;
        escape_req.code         = tctb_pkg::CH_ESCAPE;
        escape_req.repeat_count = 8'd1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Scripted opening at the reset size 80 x 25. Typed rows carry the
        // obvious answer; the rest go through the model.
        add_row(tctb_pkg::MODE_READ, 8'h00, 8'd0, 7'd0, 6'd0,
                1, 7'd0, 6'd0, tctb_pkg::SPACE_CHAR);
        add_row(tctb_pkg::MODE_READ, 8'h00, 8'd0, 7'd127, 6'd63,
                1, 7'd0, 6'd0, tctb_pkg::SPACE_CHAR);
        add_row(MODE_UNUSED, 8'hFF, 8'd255, 7'd127, 6'd63,
                1, 7'd0, 6'd0, 8'h00);
        add_row(tctb_pkg::MODE_KEY, tctb_pkg::KEY_END, 8'd1, 7'd0, 6'd0,
                1, 7'd79, 6'd0, 8'h00);
        // right and down clamp at the edge
        add_row(tctb_pkg::MODE_KEY, tctb_pkg::KEY_RIGHT, 8'd1, 7'd0, 6'd0,
                1, 7'd79, 6'd0, 8'h00);
        add_row(tctb_pkg::MODE_KEY, tctb_pkg::KEY_PGDN, 8'd1, 7'd0, 6'd0,
                1, 7'd79, 6'd24, 8'h00);
        add_row(tctb_pkg::MODE_KEY, tctb_pkg::KEY_DOWN, 8'd1, 7'd0, 6'd0,
                1, 7'd79, 6'd24, 8'h00);
        add_row(tctb_pkg::MODE_KEY, tctb_pkg::KEY_HOME, 8'd1, 7'd0, 6'd0,
                1, 7'd0, 6'd24, 8'h00);
        add_row(tctb_pkg::MODE_KEY, tctb_pkg::KEY_LEFT, 8'd1, 7'd0, 6'd0,
                1, 7'd0, 6'd24, 8'h00);
        add_row(tctb_pkg::MODE_KEY, tctb_pkg::KEY_PGUP, 8'd1, 7'd0, 6'd0,
                1, 7'd0, 6'd0, 8'h00);
        add_row(tctb_pkg::MODE_KEY, tctb_pkg::KEY_UP, 8'd1, 7'd0, 6'd0,
                1, 7'd0, 6'd0, 8'h00);
        add_row(tctb_pkg::MODE_KEY, KEY_TOP, 8'd1, 7'd0, 6'd0,
                1, 7'd0, 6'd0, 8'h00);
        // zero repeat, then backspace at column 0: both do nothing
        add_row(tctb_pkg::MODE_CHAR, 8'h41, 8'd0, 7'd0, 6'd0,
                1, 7'd0, 6'd0, 8'h00);
        add_row(tctb_pkg::MODE_CHAR, tctb_pkg::CH_BACKSPACE, 8'd3, 7'd0, 6'd0,
                1, 7'd0, 6'd0, 8'h00);
        add_row(tctb_pkg::MODE_CHAR, 8'h41, 8'd3, 7'd0, 6'd0,
                1, 7'd3, 6'd0, 8'h00);
        add_row(tctb_pkg::MODE_CHAR, tctb_pkg::CH_BACKSPACE, 8'd1, 7'd0, 6'd0,
                1, 7'd2, 6'd0, 8'h00);
        add_row(tctb_pkg::MODE_READ, 8'h00, 8'd0, 7'd1, 6'd0,
                1, 7'd2, 6'd0, 8'h41);
        add_row(tctb_pkg::MODE_CHAR, tctb_pkg::CH_TAB, 8'd1, 7'd0, 6'd0,
                1, 7'd8, 6'd0, 8'h00);
        add_row(tctb_pkg::MODE_CHAR, tctb_pkg::CH_LINEFEED, 8'd1, 7'd0, 6'd0,
                1, 7'd8, 6'd1, 8'h00);
        add_row(tctb_pkg::MODE_CHAR, tctb_pkg::CH_RETURN, 8'd1, 7'd0, 6'd0,
                1, 7'd0, 6'd2, 8'h00);
        // top byte at top repeat wraps over several rows
        add_row(tctb_pkg::MODE_CHAR, CHAR_TOP, 8'd255, 7'd0, 6'd0,
                0, 7'd0, 6'd0, 8'h00);
        add_row(tctb_pkg::MODE_KEY, tctb_pkg::KEY_DELETE, 8'd1, 7'd0, 6'd0,
                0, 7'd0, 6'd0, 8'h00);
        add_row(tctb_pkg::MODE_READ, 8'h00, 8'd0, 7'd14, 6'd5,
                0, 7'd0, 6'd0, 8'h00);
        add_row(tctb_pkg::MODE_CHAR, tctb_pkg::CH_ESCAPE, 8'd1, 7'd0, 6'd0,
                1, 7'd0, 6'd0, 8'h00);
        add_row(tctb_pkg::MODE_READ, 8'h00, 8'd0, 7'd0, 6'd2,
                1, 7'd0, 6'd0, tctb_pkg::SPACE_CHAR);

        foreach (script_rows[i])
            issue_request(script_rows[i].stim, script_rows[i].typed, script_rows[i].want);

        // Random part, one size setting per phase. Sender gaps: 38% for the
        // first third, 72% for the second, none for the last.
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            drain_reports();
            program_size(8'(PHASE_COLS[p]), 8'(PHASE_ROWS[p]));
            if (PHASE_ESC[p])
                issue_request(escape_req, 1'b0, '0);
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (random_done < RANDOM_ITEMS / 3)
                    sender_idle_pct = 38;
                else if (random_done < 2 * RANDOM_ITEMS / 3)
                    sender_idle_pct = 72;
                else
                    sender_idle_pct = 0;
                issue_request(make_random_request(), 1'b0, '0);
                random_done++;
            end
        end

        drain_reports();
        repeat (16) @(posedge clk);

        $display("Covered %0d requests (%0d scripted, %0d escapes), %0d reports checked",
                 requests_sent, script_rows.size(), escapes_sent, results_checked);
        $display("over %0d size settings from 0 x 0 up to 255 x 255, %s",
                 PHASE_COUNT + 1, "resized with and without escape");
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/tctb_pkg.sv
rtl/tctb_mem.sv
rtl/tctb_ctrl.sv
rtl/text_cell_terminal_buffer_top.sv
tb/tb_top.sv
